/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the keypad code alarm controller.
// Standalone header: no dependencies. Empty bodies when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, skipped while reset is high
`define KCAC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated during reset
`define KCAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCAC_ASSERT(lbl, clk, rst, prop, msg)
`define KCAC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* src/kcac_pkg.sv */
// Shared types and constants for the keypad code alarm controller.
// No dependencies; used by every module of the block.
package kcac_pkg;

   localparam int MAX_ENTRY   = 6;
   localparam int CNT_W       = $clog2(MAX_ENTRY + 1);
   localparam int CMP_W       = (CNT_W > 3) ? CNT_W : 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] MIN_LEN_RESET     = 3'd4;
   localparam logic [7:0] CONFIRM_KEY_RESET = 8'd35;

   typedef enum logic {
      CSR_MIN_LEN     = 1'b0,
      CSR_CONFIRM_KEY = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_KEY_STORED  = 3'd0,
      ST_KEY_DROPPED = 3'd1,
      ST_CODE_SET    = 3'd2,
      ST_MATCH       = 3'd3,
      ST_MISMATCH    = 3'd4,
      ST_MOTION      = 3'd5,
      ST_NO_MOTION   = 3'd6,
      ST_IDLE_SAMPLE = 3'd7
   } status_type;

   // Classified command handed from the front end to the executor
   typedef struct packed {
      logic       is_sample;
      logic       is_confirm;
      logic [7:0] key_char;
      logic       motion;
   } cmd_type;

   // Queue status seen by the front end and the executor
   typedef struct packed {
      logic full;
      logic valid;
   } queue_stat_type;

endpackage

/* src/keypad_code_alarm_controller.sv */
// Keypad code alarm controller: key entry, code compare, arm and alarm flags.
// An accepted request passes through the command queue and then the result register.
// Throughput: one item per cycle while results are taken; a two-entry queue between
// front end and executor and the result register let either side stall on its own.
// Reset (synchronous, active high): empty entry, setup mode, disarmed, no alarm,
// min length 4, confirm key 35; req_tready is high once reset is released.
module keypad_code_alarm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // key_char[7:0], motion_seen[8]
   input  logic                    req_tuser,   // op
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,   // status[2:0], armed_out[3], alarm_on[4],
                                                // in_setup[5], entry_count_out[8:6]
   input  logic                    csr_we,
   input  kcac_pkg::csr_index_type csr_addr,
   input  logic [7:0]              csr_wdata
);

   kcac_pkg::queue_stat_type q_stat;
   kcac_pkg::cmd_type        push_cmd;
   kcac_pkg::cmd_type        head_cmd;
   logic                     push;
   logic                     pop;
   logic [2:0]               min_len;

   kcac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_cmd   (push_cmd),
      .min_len    (min_len)
   );

   kcac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   kcac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head_cmd   (head_cmd),
      .min_len    (min_len),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* src/kcac_front.sv */
// Front end: config registers, request acceptance and key classification.
// Depends on kcac_pkg.
module kcac_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // key_char[7:0], motion_seen[8]
   input  logic                    req_tuser,   // op
   input  logic                    csr_we,
   input  kcac_pkg::csr_index_type csr_addr,
   input  logic [7:0]              csr_wdata,
   input  kcac_pkg::queue_stat_type q_stat,
   output logic                    push,
   output kcac_pkg::cmd_type       push_cmd,
   output logic [2:0]              min_len
);

   logic [2:0] min_len_ff, min_len_in;
   logic [7:0] confirm_ff, confirm_in;

   always_comb begin
      min_len_in = min_len_ff;
      confirm_in = confirm_ff;
      if (csr_we) begin
         unique case (csr_addr)
            kcac_pkg::CSR_MIN_LEN:     min_len_in = csr_wdata[2:0];
            kcac_pkg::CSR_CONFIRM_KEY: confirm_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= kcac_pkg::MIN_LEN_RESET;
         confirm_ff <= kcac_pkg::CONFIRM_KEY_RESET;
      end else begin
         min_len_ff <= min_len_in;
         confirm_ff <= confirm_in;
      end
   end

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_cmd.is_sample  = req_tuser;
      push_cmd.is_confirm = !req_tuser && (req_tdata[7:0] == confirm_ff);
      push_cmd.key_char   = req_tdata[7:0];
      push_cmd.motion     = req_tdata[8];
   end

   assign min_len = min_len_ff;

endmodule

/* src/kcac_queue.sv */
// Short command queue between the front end and the executor.
// Depends on kcac_pkg.
module kcac_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  kcac_pkg::cmd_type        push_cmd,
   input  logic                     pop,
   output kcac_pkg::cmd_type        head_cmd,
   output kcac_pkg::queue_stat_type q_stat
);

   kcac_pkg::cmd_type                 slot_ff [kcac_pkg::QUEUE_DEPTH];
   logic [kcac_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [kcac_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [kcac_pkg::QCNT_W-1:0]       count_ff, count_in;

   localparam logic [kcac_pkg::QPTR_W-1:0] LAST_PTR =
      kcac_pkg::QPTR_W'(kcac_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign q_stat.valid = (count_ff != '0);
   assign q_stat.full  = (count_ff == kcac_pkg::QCNT_W'(kcac_pkg::QUEUE_DEPTH));

endmodule

/* src/kcac_back.sv */
// Executor: entry buffer, stored code, arm/alarm flags and result register.
// Depends on kcac_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kcac_back (
   input  logic                     clock,
   input  logic                     reset,
   input  kcac_pkg::queue_stat_type q_stat,
   input  kcac_pkg::cmd_type        head_cmd,
   input  logic [2:0]               min_len,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata   // status[2:0], armed_out[3], alarm_on[4],
                                                // in_setup[5], entry_count_out[8:6]
);

   localparam int CNT_W = kcac_pkg::CNT_W;
   localparam int CMP_W = kcac_pkg::CMP_W;

   logic [7:0]       entry_ff  [kcac_pkg::MAX_ENTRY];
   logic [7:0]       entry_in  [kcac_pkg::MAX_ENTRY];
   logic [7:0]       stored_ff [kcac_pkg::MAX_ENTRY];
   logic [7:0]       stored_in [kcac_pkg::MAX_ENTRY];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] stored_len_ff, stored_len_in;
   logic             setup_ff, setup_in;
   logic             armed_ff, armed_in;
   logic             alarm_ff, alarm_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;

   kcac_pkg::status_type status;
   logic             ends_entry;
   logic             buf_full;
   logic             code_equal;
   logic             store_code;

   assign pop = q_stat.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      code_equal = (cnt_ff == stored_len_ff);
      // Only positions below the held count take part in the compare
      for (int i = 0; i < kcac_pkg::MAX_ENTRY; i++) begin
         if ((CNT_W'(i) < cnt_ff) && (entry_ff[i] != stored_ff[i])) begin
            code_equal = 1'b0;
         end
      end
   end

   assign ends_entry = !head_cmd.is_sample && head_cmd.is_confirm &&
                       (CMP_W'(cnt_ff) >= CMP_W'(min_len));
   assign buf_full   = (cnt_ff == CNT_W'(kcac_pkg::MAX_ENTRY));
   assign store_code = pop && ends_entry && setup_ff;

   always_comb begin
      entry_in      = entry_ff;
      stored_in     = stored_ff;
      cnt_in        = cnt_ff;
      stored_len_in = stored_len_ff;
      setup_in      = setup_ff;
      armed_in      = armed_ff;
      alarm_in      = alarm_ff;
      status        = kcac_pkg::ST_KEY_STORED;
      priority if (head_cmd.is_sample) begin
         if (head_cmd.motion && armed_ff) begin
            alarm_in = 1'b1;
            status   = kcac_pkg::ST_MOTION;
         end else begin
            alarm_in = 1'b0;
            status   = armed_ff ? kcac_pkg::ST_NO_MOTION : kcac_pkg::ST_IDLE_SAMPLE;
         end
      end else if (ends_entry) begin
         cnt_in = '0;
         if (setup_ff) begin
            stored_in     = entry_ff;
            stored_len_in = cnt_ff;
            armed_in      = 1'b1;
            setup_in      = 1'b0;
            status        = kcac_pkg::ST_CODE_SET;
         end else if (code_equal) begin
            armed_in = !armed_ff;
            status   = kcac_pkg::ST_MATCH;
         end else begin
            alarm_in = 1'b1;
            status   = kcac_pkg::ST_MISMATCH;
         end
      end else if (!buf_full) begin
         for (int i = 0; i < kcac_pkg::MAX_ENTRY; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               entry_in[i] = head_cmd.key_char;
            end
         end
         cnt_in = cnt_ff + 1'b1;
         status = kcac_pkg::ST_KEY_STORED;
      end else begin
         status = kcac_pkg::ST_KEY_DROPPED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, 3'(cnt_in), setup_in, armed_in && alarm_in, armed_in,
                         status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         stored_len_ff <= '0;
         setup_ff      <= 1'b1;
         armed_ff      <= 1'b0;
         alarm_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (pop) begin
         cnt_ff        <= cnt_in;
         stored_len_ff <= stored_len_in;
         setup_ff      <= setup_in;
         armed_ff      <= armed_in;
         alarm_ff      <= alarm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Contents past the held count are never compared, so no reset is needed
   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= entry_in;
      end
      if (store_code) begin
         stored_ff <= stored_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `KCAC_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(kcac_pkg::MAX_ENTRY), "entry count past buffer size")
   `KCAC_ASSERT(a_setup_disarmed, clock, reset, setup_ff |-> !armed_ff, "armed while code not set")
   `KCAC_ASSERT(a_setup_sticky, clock, reset, !setup_ff |=> !setup_ff, "setup reentered without reset")
   `KCAC_ASSERT(a_pop_gives_rsp, clock, reset, pop |=> rsp_tvalid, "executed transaction produced no result")
   `KCAC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule
